FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of the retransmit timer table.
// Depends on nothing; the using module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define RTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/rtt_pkg.sv
// Shared types and constants of the retransmit timer table.
// Depends on nothing; rtt_ctrl, retransmit_timer_table and rtt_checker import it.
package rtt_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ID_W       = 64;
  localparam int TMR_W      = 16;
  localparam int KIND_W     = 3;
  localparam int SLOT_OUT_W = 3;
  localparam int CLR_OUT_W  = 4;
  localparam int REQ_W      = 2;

  localparam logic [TMR_W-1:0] TIMEOUT_RESET   = TMR_W'(100);
  localparam logic [TMR_W-1:0] TRY_LIMIT_RESET = TMR_W'(3);

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_TRY_LIMIT = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 2'd0,
    REQ_REGISTER = 2'd1,
    REQ_ACK      = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_RETRANSMIT = 3'd2,
    KIND_FAILED     = 3'd3,
    KIND_ACK        = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [TMR_W-1:0] timer;
    logic [TMR_W-1:0] tries;
  } slot_rec_t;

  typedef struct packed {
    logic [TMR_W-1:0] timeout_load;
    logic [TMR_W-1:0] try_limit;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   pkt_id;
    logic [CNT_W-1:0]  cleared;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              rec_we;
    logic              id_we;
    logic [SLOT_W-1:0] waddr;
    slot_rec_t         rec_wdata;
    logic [ID_W-1:0]   id_wdata;
  } mem_req_t;

endpackage

FILE: rtl/rtt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; depends on nothing.
module rtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rtt_ctrl.sv
// Sequencer of the retransmit timer table: slot allocation, slot scan, result queue.
// Depends on rtt_pkg; drives the two slot memories instantiated in the top level.
module rtt_ctrl import rtt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ID_W-1:0]   pkt_id_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           res_o,
  output mem_req_t          mem_o,
  input  slot_rec_t         rec_rdata_i,
  input  logic [ID_W-1:0]   id_rdata_i
);

  state_e            state_q, state_d;
  logic [SLOT_W:0]   rd_cnt_q, rd_cnt_d;
  logic              ev_v_q, ev_v_d;
  logic [SLOT_W-1:0] ev_slot_q, ev_slot_d;
  req_e              item_type_q, item_type_d;
  logic [ID_W-1:0]   item_id_q, item_id_d;
  logic [CNT_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [SLOTS-1:0]  busy_q, busy_d;
  logic [SLOT_W-1:0] next_slot_q, next_slot_d;
  logic              pend_v_q, pend_v_d;
  result_t           pend_q, pend_d;
  logic              out_v_q, out_v_d;
  result_t           out_q, out_d;

  req_e              req;
  logic              out_free;
  logic              in_acc;
  logic              adv;
  logic              issue_v;
  logic              scan_done;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [TMR_W-1:0]  t_dec;
  logic [TMR_W-1:0]  tries_dec;
  logic              expire;
  logic              fail;
  result_t           new_res;

  assign req       = req_e'(req_type_i);
  assign out_free  = !out_v_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign adv       = (state_q == ST_SCAN) && out_free;
  assign issue_v   = rd_cnt_q < (SLOT_W + 1)'(SLOTS);
  assign scan_done = adv && !issue_v && !ev_v_q;

  // A busy slot never holds a zero timer, so the decrement cannot wrap.
  assign t_dec     = rec_rdata_i.timer - TMR_W'(1);
  assign expire    = (t_dec == '0);
  assign tries_dec = (rec_rdata_i.tries != '0) ? rec_rdata_i.tries - TMR_W'(1) : '0;
  assign fail      = expire && (tries_dec == '0);

  // Round-robin search for a free slot, starting at the next-slot pointer.
  always_comb begin
    logic [SLOT_W:0] cand;
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cand = {1'b0, next_slot_q} + (SLOT_W + 1)'(i);
      if (cand >= (SLOT_W + 1)'(SLOTS)) begin
        cand = cand - (SLOT_W + 1)'(SLOTS);
      end
      if (!free_found && !busy_q[cand[SLOT_W-1:0]]) begin
        free_found = 1'b1;
        free_slot  = cand[SLOT_W-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && ((req == REQ_TICK) || (req == REQ_ACK))) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rd_cnt_d    = rd_cnt_q;
    ev_v_d      = ev_v_q;
    ev_slot_d   = ev_slot_q;
    item_type_d = item_type_q;
    item_id_d   = item_id_q;
    clr_cnt_d   = clr_cnt_q;
    busy_d      = busy_q;
    next_slot_d = next_slot_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_v_d     = out_v_q;
    out_d       = out_q;

    mem_o           = '0;
    mem_o.re        = adv;
    mem_o.raddr     = rd_cnt_q[SLOT_W-1:0];

    new_res          = '0;
    new_res.kind     = fail ? KIND_FAILED : KIND_RETRANSMIT;
    new_res.slot     = ev_slot_q;
    new_res.pkt_id   = id_rdata_i;

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_type_d = req;
          item_id_d   = pkt_id_i;
          rd_cnt_d    = '0;
          ev_v_d      = 1'b0;
          clr_cnt_d   = '0;
          pend_v_d    = 1'b0;
          unique case (req)
            REQ_REGISTER: begin
              out_v_d          = 1'b1;
              out_d            = '0;
              out_d.pkt_id     = pkt_id_i;
              out_d.last       = 1'b1;
              if (free_found) begin
                out_d.kind            = KIND_REGISTERED;
                out_d.slot            = free_slot;
                mem_o.rec_we          = 1'b1;
                mem_o.id_we           = 1'b1;
                mem_o.waddr           = free_slot;
                mem_o.rec_wdata.timer = cfg_i.timeout_load;
                mem_o.rec_wdata.tries = cfg_i.try_limit;
                mem_o.id_wdata        = pkt_id_i;
                busy_d[free_slot]     = 1'b1;
                next_slot_d = (free_slot == SLOT_W'(SLOTS - 1)) ? '0
                                                               : free_slot + SLOT_W'(1);
              end else begin
                out_d.kind = KIND_FULL;
              end
            end
            REQ_TICK, REQ_ACK, REQ_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (adv) begin
          rd_cnt_d  = issue_v ? rd_cnt_q + (SLOT_W + 1)'(1) : rd_cnt_q;
          ev_v_d    = issue_v;
          ev_slot_d = rd_cnt_q[SLOT_W-1:0];

          if (ev_v_q && busy_q[ev_slot_q]) begin
            if (item_type_q == REQ_ACK) begin
              if (id_rdata_i == item_id_q) begin
                busy_d[ev_slot_q] = 1'b0;
                clr_cnt_d         = clr_cnt_q + CNT_W'(1);
              end
            end else begin
              mem_o.rec_we = 1'b1;
              mem_o.waddr  = ev_slot_q;
              if (!expire) begin
                mem_o.rec_wdata.timer = t_dec;
                mem_o.rec_wdata.tries = rec_rdata_i.tries;
              end else begin
                if (fail) begin
                  mem_o.rec_wdata   = '0;
                  busy_d[ev_slot_q] = 1'b0;
                end else begin
                  mem_o.rec_wdata.timer = cfg_i.timeout_load;
                  mem_o.rec_wdata.tries = tries_dec;
                end
                // The held result goes out once a later one proves it is not last, or as last at scan end.
                if (pend_v_q) begin
                  out_v_d = 1'b1;
                  out_d   = pend_q;
                end
                pend_v_d = 1'b1;
                pend_d   = new_res;
              end
            end
          end

          if (!issue_v && !ev_v_q) begin
            if (item_type_q == REQ_ACK) begin
              out_v_d          = 1'b1;
              out_d            = '0;
              out_d.kind       = KIND_ACK;
              out_d.pkt_id     = item_id_q;
              out_d.cleared    = clr_cnt_q;
              out_d.last       = 1'b1;
            end else if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_d.last = 1'b1;
              pend_v_d   = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      ev_v_q      <= 1'b0;
      busy_q      <= '0;
      next_slot_q <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      ev_v_q      <= ev_v_d;
      busy_q      <= busy_d;
      next_slot_q <= next_slot_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_slot_q   <= ev_slot_d;
    item_type_q <= item_type_d;
    item_id_q   <= item_id_d;
    clr_cnt_q   <= clr_cnt_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

FILE: rtl/retransmit_timer_table.sv
// A register request gives its single result in the cycle after the item is accepted.
// A tick or an ack scans every slot, one slot per cycle through the slot memories while
// the result channel is not stalled. Register requests are taken one per cycle while the
// result channel is not stalled; no new item is taken until a tick or ack scan is done.
// Reset clears all busy flags (every slot free), the next-slot pointer and the output stage;
// the timeout returns to 100 and try_limit to 3. No clearing pass is needed after reset.
module retransmit_timer_table import rtt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [TMR_W-1:0]      cfg_wdata_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [ID_W-1:0]       pkt_id_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [ID_W-1:0]       out_pkt_id_o,
  output logic [CLR_OUT_W-1:0]  cleared_count_o,
  output logic                  last_o
);

  // Each slot keeps its wait timer and try count in one memory word and its frame id in a
  // second memory. Whether a slot is busy lives in a flip-flop per slot, which is what lets
  // reset free the whole table at once; a free slot's memory words are never looked at.

  logic [TMR_W-1:0] timeout_q, timeout_d;
  logic [TMR_W-1:0] try_limit_q, try_limit_d;
  cfg_t             cfg;
  mem_req_t         mem_req;
  slot_rec_t        rec_rdata;
  logic [ID_W-1:0]  id_rdata;
  result_t          res;

  always_comb begin
    timeout_d   = timeout_q;
    try_limit_d = try_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT:   timeout_d   = cfg_wdata_i;
        CFG_TRY_LIMIT: try_limit_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      try_limit_q <= TRY_LIMIT_RESET;
    end else begin
      timeout_q   <= timeout_d;
      try_limit_q <= try_limit_d;
    end
  end

  // A zero timeout is loaded as one so that a busy slot never holds a zero timer.
  assign cfg.timeout_load = (timeout_q == '0) ? TMR_W'(1) : timeout_q;
  assign cfg.try_limit    = try_limit_q;

  rtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .pkt_id_i    (pkt_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .mem_o       (mem_req),
    .rec_rdata_i (rec_rdata),
    .id_rdata_i  (id_rdata)
  );

  // Timer and try-count memory: written by registration and by every tick update.
  rtt_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.rec_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.rec_wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rec_rdata)
  );

  // Frame id memory: written only when a frame is registered.
  rtt_ram #(
    .WIDTH (ID_W),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.id_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.id_wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (id_rdata)
  );

  assign kind_o          = KIND_W'(res.kind);
  assign slot_o          = SLOT_OUT_W'(res.slot);
  assign out_pkt_id_o    = res.pkt_id;
  assign cleared_count_o = CLR_OUT_W'(res.cleared);
  assign last_o          = res.last;

endmodule

FILE: rtl/rtt_checker.sv
// Port-level checker of the retransmit timer table and its bind statement.
// Depends on rtt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtt_checker import rtt_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [REQ_W-1:0]      req_type_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [KIND_W-1:0]     kind_o,
  input logic [SLOT_OUT_W-1:0] slot_o,
  input logic [ID_W-1:0]       out_pkt_id_o,
  input logic [CLR_OUT_W-1:0]  cleared_count_o,
  input logic                  last_o
);

  `RTT_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_pkt_id_o),
    "stalled result changed")
  `RTT_ASSERT(a_reg_answer,
    in_valid_i && !in_stall_o && req_type_i == REQ_REGISTER
      |=> out_valid_o && last_o && (kind_o == KIND_REGISTERED || kind_o == KIND_FULL),
    "register request not answered next cycle")
  `RTT_ASSERT(a_ack_last,
    out_valid_o && kind_o == KIND_ACK |-> last_o && slot_o == '0,
    "ack result not final or slot set")
  `RTT_ASSERT(a_full_clean,
    out_valid_o && kind_o == KIND_FULL |-> slot_o == '0 && cleared_count_o == '0,
    "table full result carries slot or count")
  `RTT_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind retransmit_timer_table rtt_checker u_rtt_checker (.*);
